@@ design/lge_pkg.sv @@
// ----------------------------------------------------------------------------
// lge_pkg: shared types and constants of the life grid engine
// command codes, field widths, B3/S23 rule counts and the 3x3 window type
// ----------------------------------------------------------------------------
package lge_pkg;

  localparam int CMD_W = 2;
  localparam int IDX_W = 12;
  localparam int GEN_W = 10;
  localparam int DIM_W = 7;

  // grid side after reset
  localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE   = 2'd0,
    CMD_ADVANCE = 2'd1,
    CMD_READ    = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  // live neighbor counts of the rule
  localparam logic [3:0] BIRTH_COUNT = 4'd3;
  localparam logic [3:0] STAY_COUNT  = 4'd2;

  // 3x3 neighborhood, bit 2 left, bit 1 center, bit 0 right
  typedef struct packed {
    logic [2:0] above;
    logic [2:0] level;
    logic [2:0] below;
  } window_t;

endpackage

@@ design/lge_cell.sv @@
// ----------------------------------------------------------------------------
// lge_cell: next state of one grid column
// counts the eight neighbors of the window and applies the B3/S23 rule
// ----------------------------------------------------------------------------
module lge_cell (
  input  lge_pkg::window_t win,
  output logic             alive
);

  logic [3:0] count;

  always_comb begin
    count = 4'({3'd0, win.above[2]}) + 4'({3'd0, win.above[1]})
          + 4'({3'd0, win.above[0]}) + 4'({3'd0, win.level[2]})
          + 4'({3'd0, win.level[0]}) + 4'({3'd0, win.below[2]})
          + 4'({3'd0, win.below[1]}) + 4'({3'd0, win.below[0]});
    // self sits in the center of the middle row
    alive = (count == lge_pkg::BIRTH_COUNT)
         || (win.level[1] && (count == lge_pkg::STAY_COUNT));
  end

endmodule

@@ design/lge_row_stage.sv @@
// ----------------------------------------------------------------------------
// lge_row_stage: one row of the grid ring
// holds a full row and takes its neighbor's row on every shift
// ----------------------------------------------------------------------------
module lge_row_stage #(
  parameter int W = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         shift,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] row;

  // reset leaves every cell dead
  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0;
    end else if (shift) begin
      row <= d;
    end
  end

  assign q = row;

endmodule

@@ design/life_grid_generation_engine.sv @@
// ----------------------------------------------------------------------------
// life_grid_generation_engine: Conway B3/S23 engine on a bounded square grid
// write, read and multi-generation advance over a ring of row stages
// ----------------------------------------------------------------------------
// The grid lives in a ring of MAX_DIM row stages that rotates one row per
// cycle during a walk or an advance and stands still otherwise; reads,
// writes and advances are served while the ring turns past a fixed head.
// A write or a read takes one full turn, then the strobe done comes. An
// advance of g generations takes g full turns before its strobe comes.
// An advance of zero generations and the unused command code
// give their strobe in the cycle after accept. busy stays high until the
// strobe cycle has passed, so one command is in flight at a time. Results
// cannot be held off: read_value and done_command are valid only in the
// cycle where done is high. grid_dim is written over the cfg channel while
// busy is low; rows and columns beyond the active side keep their contents.
// ----------------------------------------------------------------------------
module life_grid_generation_engine #(
  parameter int MAX_DIM = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  // command beat
  input  logic                      start,
  output logic                      busy,
  input  logic [lge_pkg::CMD_W-1:0] command,
  input  logic [lge_pkg::IDX_W-1:0] cell_index,
  input  logic                      cell_value,
  input  logic [lge_pkg::GEN_W-1:0] generations,
  // result beat
  output logic                      done,
  output logic                      read_value,
  output logic [lge_pkg::CMD_W-1:0] done_command,
  // grid_dim register write
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [lge_pkg::DIM_W-1:0] cfg_data
);

  localparam int CW = $clog2(MAX_DIM);              // head row / column index
  localparam int SW = $clog2(MAX_DIM + 1);          // active side
  localparam int ZW = SW + 1;                       // side compares
  localparam int KW = (SW > lge_pkg::DIM_W) ? SW : lge_pkg::DIM_W;
  localparam int BW = $clog2(MAX_DIM * (MAX_DIM + 1) + 1);  // row base
  localparam int IW = (BW > lge_pkg::IDX_W) ? BW : lge_pkg::IDX_W;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_WALK = 4'b0010,   // one turn for a read or a write
    ST_GEN  = 4'b0100,   // one turn per generation
    ST_DONE = 4'b1000    // result beat
  } state_t;

  state_t                      state, state_next;
  logic [lge_pkg::DIM_W-1:0]   grid_dim;
  logic [CW-1:0]               hrow;        // grid row sitting at the head
  logic [BW-1:0]               base;        // hrow * side during a walk
  logic [lge_pkg::GEN_W-1:0]   gens_left;
  logic [lge_pkg::IDX_W-1:0]   idx_q;
  logic                        val_q;
  logic [lge_pkg::CMD_W-1:0]   cmd_q;
  logic                        rd_q;
  logic [MAX_DIM-1:0]          prior_old;   // old contents of the row above

  logic [MAX_DIM-1:0]          ring_q [MAX_DIM];
  logic [MAX_DIM-1:0]          ring_d [MAX_DIM];
  logic [MAX_DIM-1:0]          tail_in;
  logic                        shift;

  logic [SW-1:0]               side;
  logic [KW-1:0]               dim_k;
  logic                        row_active;
  logic                        has_next;
  logic                        last_row;
  logic                        hit;
  logic [IW-1:0]               idx_ext;
  logic [IW-1:0]               base_ext;
  logic [CW-1:0]               col;
  logic [MAX_DIM-1:0]          col_mask;
  logic [MAX_DIM-1:0]          up_m, mid_m, dn_m;
  logic [MAX_DIM-1:0]          rule_row;
  logic [MAX_DIM-1:0]          gen_row;
  logic [MAX_DIM-1:0]          wr_row;
  logic                        accept;

  assign accept    = start && (state == ST_IDLE);
  assign busy      = (state != ST_IDLE);
  assign cfg_ready = (state == ST_IDLE);
  assign done      = (state == ST_DONE);
  assign read_value   = rd_q;
  assign done_command = cmd_q;

  // active side: zero acts as one, saturate at the ring size
  always_comb begin
    dim_k = KW'(grid_dim);
    if (dim_k == '0) begin
      side = SW'(1);
    end else if (dim_k > KW'(MAX_DIM)) begin
      side = SW'(MAX_DIM);
    end else begin
      side = SW'(dim_k);
    end
  end

  assign row_active = ZW'(hrow) < ZW'(side);
  assign has_next   = (ZW'(hrow) + ZW'(1)) < ZW'(side);
  assign last_row   = (hrow == CW'(MAX_DIM - 1));

  // row-major index lands in the head row when base <= idx < base + side
  assign idx_ext  = IW'(idx_q);
  assign base_ext = IW'(base);
  assign hit      = row_active && (idx_ext >= base_ext)
                 && (idx_ext < base_ext + IW'(side));
  assign col      = CW'(idx_ext - base_ext);

  // ring of row stages, head at stage 0, new rows enter at the tail
  for (genvar i = 0; i < MAX_DIM; i++) begin : g_ring
    if (i == MAX_DIM - 1) begin : g_tail
      assign ring_d[i] = tail_in;
    end else begin : g_link
      assign ring_d[i] = ring_q[i+1];
    end
    lge_row_stage #(.W(MAX_DIM)) u_row (
      .clk   (clk),
      .rst   (rst),
      .shift (shift),
      .d     (ring_d[i]),
      .q     (ring_q[i])
    );
  end

  // neighborhood rows, cut to the active square; off-grid rows are dead
  for (genvar c = 0; c < MAX_DIM; c++) begin : g_mask
    assign col_mask[c] = ZW'(c) < ZW'(side);
  end
  assign up_m  = (hrow != '0) ? (prior_old & col_mask) : '0;
  assign mid_m = ring_q[0] & col_mask;
  assign dn_m  = has_next ? (ring_q[1] & col_mask) : '0;

  // one rule cell per column
  for (genvar c = 0; c < MAX_DIM; c++) begin : g_col
    lge_pkg::window_t win;
    if (c == 0) begin : g_left_edge
      assign win.above[2] = 1'b0;
      assign win.level[2] = 1'b0;
      assign win.below[2] = 1'b0;
    end else begin : g_left
      assign win.above[2] = up_m[c-1];
      assign win.level[2] = mid_m[c-1];
      assign win.below[2] = dn_m[c-1];
    end
    if (c == MAX_DIM - 1) begin : g_right_edge
      assign win.above[0] = 1'b0;
      assign win.level[0] = 1'b0;
      assign win.below[0] = 1'b0;
    end else begin : g_right
      assign win.above[0] = up_m[c+1];
      assign win.level[0] = mid_m[c+1];
      assign win.below[0] = dn_m[c+1];
    end
    assign win.above[1] = up_m[c];
    assign win.level[1] = mid_m[c];
    assign win.below[1] = dn_m[c];
    lge_cell u_cell (
      .win   (win),
      .alive (rule_row[c])
    );
  end

  // columns past the side keep their old bits
  assign gen_row = (rule_row & col_mask) | (ring_q[0] & ~col_mask);

  always_comb begin
    wr_row = ring_q[0];
    wr_row[col] = val_q;
  end

  // what re-enters the ring at the tail
  always_comb begin
    tail_in = ring_q[0];
    case (state)
      ST_GEN: begin
        if (row_active) begin
          tail_in = gen_row;
        end
      end
      ST_WALK: begin
        if (hit && (cmd_q == lge_pkg::CMD_WRITE)) begin
          tail_in = wr_row;
        end
      end
      default: begin
        tail_in = ring_q[0];
      end
    endcase
  end

  assign shift = (state == ST_WALK) || (state == ST_GEN);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (lge_pkg::cmd_t'(command))
            lge_pkg::CMD_WRITE,
            lge_pkg::CMD_READ:    state_next = ST_WALK;
            lge_pkg::CMD_ADVANCE: state_next = (generations != '0) ? ST_GEN : ST_DONE;
            default:              state_next = ST_DONE;
          endcase
        end
      end
      ST_WALK: begin
        if (last_row) begin
          state_next = ST_DONE;
        end
      end
      ST_GEN: begin
        if (last_row && (gens_left == lge_pkg::GEN_W'(1))) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      grid_dim  <= lge_pkg::DIM_RESET;
      hrow      <= '0;
      prior_old <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        grid_dim <= cfg_data;
      end
      if (shift) begin
        hrow      <= last_row ? '0 : hrow + CW'(1);
        prior_old <= ring_q[0];
      end
    end
  end

  // command payload and walk bookkeeping
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q     <= command;
      idx_q     <= cell_index;
      val_q     <= cell_value;
      gens_left <= generations;
      base      <= '0;
      rd_q      <= 1'b0;
    end else begin
      if (state == ST_WALK) begin
        base <= base + BW'(side);
        if (hit && (cmd_q == lge_pkg::CMD_READ)) begin
          rd_q <= ring_q[0][col];
        end
      end
      if ((state == ST_GEN) && last_row) begin
        gens_left <= gens_left - lge_pkg::GEN_W'(1);
      end
    end
  end

endmodule

@@ tb/sv/life_grid_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// life_grid_checker: result checker for the life grid engine
// keeps a shadow grid, predicts every command beat and compares result beats
// ----------------------------------------------------------------------------
module life_grid_checker #(
  parameter int MAX_DIM = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic                      busy,
  input  logic [lge_pkg::CMD_W-1:0] command,
  input  logic [lge_pkg::IDX_W-1:0] cell_index,
  input  logic                      cell_value,
  input  logic [lge_pkg::GEN_W-1:0] generations,
  input  logic                      done,
  input  logic                      read_value,
  input  logic [lge_pkg::CMD_W-1:0] done_command,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [lge_pkg::DIM_W-1:0] cfg_data,
  output int                        mismatches,
  output int                        in_flight
);
  import lge_pkg::*;

  typedef struct packed {
    logic read_value;
    cmd_t done_command;
  } cell_result_t;

  logic [DIM_W-1:0]   grid_dim;
  logic [MAX_DIM-1:0] shadow_grid [MAX_DIM];
  cell_result_t       pending_results [$];
  cell_result_t       oldest;
  cell_result_t       predicted;

  task automatic report(string what, int got, int want);
    $display("%0t ns: %s mismatch, got %0d want %0d", $time, what, got, want);
    mismatches++;
  endtask

  // updates the shadow grid and returns the result beat this command must give
  function automatic cell_result_t apply_command(cmd_t op, int idx, logic val, int gens);
    cell_result_t       res;
    int                 side;
    int                 row;
    int                 col;
    logic [MAX_DIM-1:0] old_rows [MAX_DIM];
    logic [MAX_DIM-1:0] taps [8];
    logic [MAX_DIM-1:0] mask, up, mid, dn, c0, c1, c2, c3, k0, k1, k2, eq2, eq3;

    side = (grid_dim == 0) ? 1 : (grid_dim > MAX_DIM) ? MAX_DIM : int'(grid_dim);
    row = idx / side;
    col = idx % side;
    res.read_value = 1'b0;
    res.done_command = op;
    case (op)
      CMD_WRITE: begin
        if (row < side) shadow_grid[row][col] = val;
      end
      CMD_READ: begin
        if (row < side) res.read_value = shadow_grid[row][col];
      end
      CMD_ADVANCE: begin
        mask = '0;
        for (int c = 0; c < side; c++) mask[c] = 1'b1;
        for (int g = 0; g < gens; g++) begin
          old_rows = shadow_grid;
          for (int r = 0; r < side; r++) begin
            up  = (r > 0) ? old_rows[r-1] & mask : '0;
            mid = old_rows[r] & mask;
            dn  = (r + 1 < side) ? old_rows[r+1] & mask : '0;
            taps = '{up << 1, up, up >> 1, mid << 1, mid >> 1, dn << 1, dn, dn >> 1};
            // bit-sliced neighbor count, c3 sticks once the count reaches 8
            c0 = '0; c1 = '0; c2 = '0; c3 = '0;
            for (int k = 0; k < 8; k++) begin
              k0 = c0 & taps[k];
              c0 = c0 ^ taps[k];
              k1 = c1 & k0;
              c1 = c1 ^ k0;
              k2 = c2 & k1;
              c2 = c2 ^ k1;
              c3 = c3 | k2;
            end
            eq3 = c0 & c1 & ~c2 & ~c3;
            eq2 = ~c0 & c1 & ~c2 & ~c3;
            shadow_grid[r] = (old_rows[r] & ~mask) | ((eq3 | (mid & eq2)) & mask);
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      grid_dim = DIM_RESET;
      for (int r = 0; r < MAX_DIM; r++) shadow_grid[r] = '0;
      pending_results.delete();
      mismatches = 0;
      in_flight <= 0;
    end else begin
      if (done) begin
        if (pending_results.size() == 0) begin
          report("unexpected result beat, done_command", int'(done_command), -1);
        end else begin
          oldest = pending_results.pop_front();
          if (read_value !== oldest.read_value)
            report("read_value", int'(read_value), int'(oldest.read_value));
          if (done_command !== oldest.done_command)
            report("done_command", int'(done_command), int'(oldest.done_command));
        end
      end
      // a grid_dim beat on the same edge as a command beat already sets its side
      if (cfg_valid && cfg_ready) grid_dim = cfg_data;
      if (start && !busy) begin
        predicted = apply_command(cmd_t'(command), int'(cell_index),
                                  cell_value, int'(generations));
        pending_results = {pending_results, predicted};
      end
      in_flight <= pending_results.size();
    end
  end

endmodule

@@ tb/sv/life_grid_generation_engine_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// life_grid_generation_engine_tb: regression for the life grid engine
// directed corner cases, then random phases of cell writes, reads and
// multi-generation advances over many grid sizes; the checker predicts
// every result beat and this top gives the verdict
// ----------------------------------------------------------------------------
module life_grid_generation_engine_tb;
  import lge_pkg::*;

  localparam int MAX_DIM     = 64;
  localparam int ITEM_TARGET = 2000;
  // keep a wide margin over the slowest legal run
  localparam int CYCLE_LIMIT = 4_000_000;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  cmd_t             command = CMD_WRITE;
  logic [IDX_W-1:0] cell_index = '0;
  logic             cell_value = 1'b0;
  logic [GEN_W-1:0] generations = '0;
  logic             done;
  logic             read_value;
  logic [CMD_W-1:0] done_command;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [DIM_W-1:0] cfg_data = '0;

  int    mismatches;
  int    in_flight;
  int    cycles = 0;

  // stimulus bookkeeping
  int    side = MAX_DIM;
  int    burst_left = 0;
  int    items_sent = 0;
  int    op_count [4] = '{0, 0, 0, 0};
  int    dim_writes = 0;
  longint gens_total = 0;
  int    dim_extremes [6] = '{0, 1, 2, 64, 65, 127};

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  life_grid_generation_engine #(
    .MAX_DIM(MAX_DIM)
  ) DUT (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .command     (command),
    .cell_index  (cell_index),
    .cell_value  (cell_value),
    .generations (generations),
    .done        (done),
    .read_value  (read_value),
    .done_command(done_command),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data)
  );

  life_grid_checker #(
    .MAX_DIM(MAX_DIM)
  ) grid_check (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .command     (command),
    .cell_index  (cell_index),
    .cell_value  (cell_value),
    .generations (generations),
    .done        (done),
    .read_value  (read_value),
    .done_command(done_command),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .in_flight   (in_flight)
  );

  // watchdog: a hung handshake or a lost result ends here
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("watchdog expired after %0d cycles, %0d results outstanding", cycles, in_flight);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // one command beat; start stays high across a burst, then drops for a gap
  // counted from the accepting edge so gaps land anywhere in the busy window
  task automatic issue(cmd_t op, int idx, logic val, int gens);
    int gap;
    start       <= 1'b1;
    command     <= op;
    cell_index  <= idx[IDX_W-1:0];
    cell_value  <= val;
    generations <= gens[GEN_W-1:0];
    do @(posedge clk); while (busy);
    items_sent++;
    op_count[op]++;
    if (op == CMD_ADVANCE) gens_total += gens;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      // mostly short bursts, now and then a long run with no idling
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 4);
      case ($urandom_range(0, 9))
        0:       gap = $urandom_range(41, 90);
        1, 2:    gap = $urandom_range(5, 40);
        default: gap = $urandom_range(1, 4);
      endcase
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // drop start and wait until every expected result beat has come back
  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (in_flight != 0 || busy);
  endtask

  // grid_dim write, only with the engine idle
  task automatic set_grid_dim(int dim);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= dim[DIM_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    side = (dim == 0) ? 1 : (dim > MAX_DIM) ? MAX_DIM : dim;
    dim_writes++;
  endtask

  initial begin
    cmd_t op;
    int   sel;
    int   dim;
    int   idx;
    int   gens;
    logic val;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---- directed part, grid side 64 from reset ----
    // all four corners alive, one read back
    issue(CMD_WRITE, 0, 1'b1, 0);
    issue(CMD_WRITE, 63, 1'b1, 1023);
    issue(CMD_WRITE, 4032, 1'b1, 0);
    issue(CMD_WRITE, 4095, 1'b1, 0);
    issue(CMD_READ, 4095, 1'b0, 0);
    // horizontal blinker in row 10, one step turns it vertical
    issue(CMD_WRITE, 10 * 64 + 10, 1'b1, 0);
    issue(CMD_WRITE, 10 * 64 + 11, 1'b1, 0);
    issue(CMD_WRITE, 10 * 64 + 12, 1'b1, 0);
    issue(CMD_ADVANCE, 0, 1'b0, 1);
    issue(CMD_READ, 9 * 64 + 11, 1'b0, 0);
    issue(CMD_READ, 10 * 64 + 10, 1'b0, 0);
    // zero generations leaves the grid alone
    issue(CMD_ADVANCE, 4095, 1'b1, 0);
    // unused command code with every field at its top
    issue(CMD_NONE, 4095, 1'b1, 1023);
    // longest advance, lone corner cells die
    issue(CMD_ADVANCE, 0, 1'b0, 1023);
    issue(CMD_READ, 0, 1'b0, 0);
    issue(CMD_READ, 9 * 64 + 11, 1'b0, 0);

    // small grid: indexes past the last row are out of range
    set_grid_dim(3);
    issue(CMD_WRITE, 8, 1'b1, 0);
    issue(CMD_WRITE, 9, 1'b1, 0);
    issue(CMD_READ, 9, 1'b0, 0);
    issue(CMD_READ, 4095, 1'b0, 0);

    // side 0 behaves as a single cell
    set_grid_dim(0);
    issue(CMD_WRITE, 1, 1'b1, 0);
    issue(CMD_WRITE, 0, 1'b1, 0);
    issue(CMD_ADVANCE, 0, 1'b0, 1);
    issue(CMD_READ, 0, 1'b0, 0);

    // oversize side saturates, the cell written at side 3 shows up again
    set_grid_dim(127);
    issue(CMD_READ, 2 * 64 + 2, 1'b0, 0);

    // ---- random phases, each at a fresh grid side ----
    while (items_sent < ITEM_TARGET) begin
      sel = $urandom_range(0, 9);
      if (sel < 2) dim = dim_extremes[$urandom_range(0, 5)];
      else if (sel < 7) dim = $urandom_range(3, 12);
      else dim = $urandom_range(13, 64);
      set_grid_dim(dim);

      repeat ($urandom_range(40, 160)) begin
        sel = $urandom_range(0, 99);
        if (sel < 38) op = CMD_WRITE;
        else if (sel < 76) op = CMD_READ;
        else if (sel < 94) op = CMD_ADVANCE;
        else op = CMD_NONE;

        // mostly inside the active grid, some anywhere in the index space
        idx = ($urandom_range(0, 9) < 8) ? $urandom_range(0, side * side - 1)
                                         : $urandom_range(0, 4095);
        val = ($urandom_range(0, 99) < 55);

        if (op == CMD_ADVANCE) begin
          // short advances keep the run fast, a rare one goes the full range
          sel = $urandom_range(0, 99);
          if (sel < 45) gens = 1;
          else if (sel < 75) gens = $urandom_range(0, 4);
          else if (sel < 98) gens = $urandom_range(5, 24);
          else gens = $urandom_range(0, 1023);
        end else begin
          gens = $urandom_range(0, 1023);
        end
        issue(op, idx, val, gens);
      end
    end

    // drain, then give a stray late beat time to show up
    settle();
    repeat (2 * MAX_DIM) @(posedge clk);

    $display("ran %0d commands: %0d writes, %0d reads, %0d advances, %0d unused codes",
             items_sent, op_count[CMD_WRITE], op_count[CMD_READ],
             op_count[CMD_ADVANCE], op_count[CMD_NONE]);
    $display("%0d grid side changes, %0d generations stepped, %0d cycles",
             dim_writes, gens_total, cycles);
    if (mismatches == 0 && in_flight == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/lge_pkg.sv
design/lge_cell.sv
design/lge_row_stage.sv
design/life_grid_generation_engine.sv
tb/sv/life_grid_checker.sv
tb/sv/life_grid_generation_engine_tb.sv
